[rtl/mnic_pkg.sv]
`default_nettype none

package mnic_pkg;

    localparam int MODULUS   = 5;
    localparam int PARAM_M   = 2;
    localparam int PARAM_N   = 4;
    localparam int IMG_COUNT = MODULUS * MODULUS * MODULUS * MODULUS;

    localparam int COEF_W    = 3;
    localparam int XV_W      = 2;
    localparam int PROD_W    = COEF_W + 1 + XV_W;
    localparam int ACC_W     = 8;
    localparam int TAB_DEPTH = 1 << ACC_W;
    localparam int RES_W     = $clog2(MODULUS);
    localparam int LANE_W    = $clog2(PARAM_N);
    localparam int ROW_W     = $clog2(PARAM_M);
    localparam int ADDR_W    = $clog2(IMG_COUNT);
    localparam int CNT_W     = $clog2(IMG_COUNT + 1);
    localparam int EP_W      = 4;
    localparam int EP_MAX    = (1 << EP_W) - 1;

    localparam int CFG_NUM   = PARAM_M * PARAM_N;
    localparam int CFG_IDX_W = 4;

    localparam int IN_DATA_W  = PARAM_M * PARAM_N * XV_W;
    localparam int IMG_W      = 10;
    localparam int DIST_W     = 10;
    localparam int OUT_FLD_W  = IMG_W + 1 + DIST_W + 1;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic signed [XV_W-1:0]   t_xval;
    typedef t_coef                    t_mat [PARAM_M][PARAM_N];
    typedef t_xval                    t_vec [PARAM_M][PARAM_N];
    typedef logic [RES_W-1:0]         t_res;
    typedef t_res                     t_res_vec [PARAM_N];
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [EP_W-1:0]          t_ep;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef t_res                     t_mod_tab [TAB_DEPTH];

    // request leaving the lane stage toward the merge
    typedef struct packed {
        logic vld;
        logic last;
        t_ep  ep;
    } t_stage;

    typedef struct packed {
        logic  active;
        t_addr addr;
    } t_clr;

    typedef struct packed {
        logic en;
        logic b_vld;
    } t_mstat;

    // residue of every two's complement accumulator pattern, built by counting
    function automatic t_mod_tab build_mod_tab();
        t_mod_tab t;
        int       r;
        r = 0;
        for (int s = 0; s < TAB_DEPTH / 2; s++) begin
            t[s] = RES_W'(r);
            r = (r == MODULUS - 1) ? 0 : r + 1;
        end
        r = 0;
        for (int s = 1; s <= TAB_DEPTH / 2; s++) begin
            r = (r == 0) ? MODULUS - 1 : r - 1;
            t[TAB_DEPTH - s] = RES_W'(r);
        end
        return t;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

    function automatic t_addr img_weight(input int pos);
        int w;
        w = 1;
        for (int i = 0; i < pos; i++) begin
            w = w * MODULUS;
        end
        return ADDR_W'(w);
    endfunction

endpackage

`default_nettype wire

[rtl/mnic_ram.sv]
`default_nettype none

module mnic_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 625
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/mnic_lane.sv]
`default_nettype none

module mnic_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire logic [mnic_pkg::LANE_W-1:0] i_lane,
    input  wire mnic_pkg::t_mat              i_mat,
    input  wire mnic_pkg::t_vec              i_vec,
    output mnic_pkg::t_res                   o_res
);
    import mnic_pkg::*;

    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;

    // one output coefficient: terms that wrap past x^3 come back negated
    always_comb begin
        logic        [LANE_W-1:0] j;
        logic signed [PROD_W-1:0] p;
        n_acc = '0;
        j     = '0;
        p     = '0;
        for (int k = 0; k < PARAM_M; k++) begin
            for (int i = 0; i < PARAM_N; i++) begin
                j = LANE_W'(i_lane - LANE_W'(i));
                p = $signed({1'b0, i_mat[k][i]}) * i_vec[k][j];
                if (LANE_W'(i) > i_lane) begin
                    n_acc = n_acc - ACC_W'(p);
                end else begin
                    n_acc = n_acc + ACC_W'(p);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= n_acc;
        end
    end

    assign o_res = MOD_TAB[$unsigned(r_acc)];

endmodule

`default_nettype wire

[rtl/mnic_merge.sv]
`default_nettype none

module mnic_merge (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mnic_pkg::t_res_vec              i_res,
    input  wire mnic_pkg::t_stage                i_a,
    input  wire mnic_pkg::t_clr                  i_clr,
    output mnic_pkg::t_mstat                     o_stat,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // image_index[9:0], first_seen[10], distinct_so_far[20:11], covers_all[21], zero
    output logic [mnic_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // run_end
    output logic                                 o_m_axis_tlast
);
    import mnic_pkg::*;

    logic  en;
    logic  commit;
    t_addr idx_a;
    t_ep   rdata;
    logic  hit;
    logic  fresh;
    t_cnt  cnt_new;
    logic  we;
    t_addr waddr;
    t_ep   wdata;

    logic  r_b_vld;
    t_addr r_b_idx;
    logic  r_b_last;
    t_ep   r_b_ep;

    logic  r_fw_vld;
    t_addr r_fw_idx;
    t_ep   r_fw_ep;
    t_cnt  r_cnt;

    logic  r_out_vld;
    t_addr r_out_idx;
    logic  r_out_fresh;
    t_cnt  r_out_dist;
    logic  r_out_cover;
    logic  r_out_last;

    assign en     = !r_out_vld || i_m_axis_tready;
    assign commit = en && r_b_vld;

    // base q packing, coefficient 0 least significant
    always_comb begin
        idx_a = '0;
        for (int i = 0; i < PARAM_N; i++) begin
            idx_a = idx_a + t_addr'(i_res[i]) * img_weight(i);
        end
    end

    assign we    = i_clr.active || commit;
    assign waddr = i_clr.active ? i_clr.addr : r_b_idx;
    assign wdata = i_clr.active ? '0 : r_b_ep;

    mnic_ram #(
        .WIDTH (EP_W),
        .DEPTH (IMG_COUNT)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (en),
        .i_raddr (idx_a),
        .o_rdata (rdata)
    );

    // the write of the item just ahead lands in the cycle this item was read
    assign hit     = (rdata == r_b_ep) ||
                     (r_fw_vld && r_fw_idx == r_b_idx && r_fw_ep == r_b_ep);
    assign fresh   = !hit;
    assign cnt_new = r_cnt + t_cnt'(fresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (en) begin
                r_b_vld   <= i_a.vld;
                r_out_vld <= r_b_vld;
            end
            if (commit) begin
                r_fw_vld <= 1'b1;
                r_cnt    <= r_b_last ? '0 : cnt_new;
            end
            if (i_clr.active) begin
                r_fw_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_idx  <= idx_a;
            r_b_last <= i_a.last;
            r_b_ep   <= i_a.ep;
        end
        if (commit) begin
            r_fw_idx    <= r_b_idx;
            r_fw_ep     <= r_b_ep;
            r_out_idx   <= r_b_idx;
            r_out_fresh <= fresh;
            r_out_dist  <= cnt_new;
            r_out_cover <= r_b_last && (cnt_new == t_cnt'(IMG_COUNT));
            r_out_last  <= r_b_last;
        end
    end

    assign o_stat.en    = en;
    assign o_stat.b_vld = r_b_vld;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_cover, DIST_W'(r_out_dist),
                                          r_out_fresh, IMG_W'(r_out_idx)});

`ifndef ASSERT_OFF
    a_no_clear_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr.active |-> !r_b_vld && !i_a.vld)
        else $error("seen map cleared with an item in flight");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_dist != '0)
        else $error("delivered result with zero distinct count");

    a_cover_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_cover) |-> r_out_last && r_out_dist == t_cnt'(IMG_COUNT))
        else $error("coverage flag outside a full run end");
`endif

endmodule

`default_nettype wire

[rtl/module_negacyclic_image_counter.sv]
`default_nettype none

// Computes y = a0*x0 + a1*x1 in Z_5[x]/(x^4+1) for each short vector on the slave
// stream and returns, one result per vector, the image index of y, whether it is new
// in the run, the running distinct count and, on the vector marked tlast, whether all
// 625 images occurred. One vector is taken every cycle unless stalled or sweeping; a
// result passes the lane, merge and output registers, and back pressure on the master
// side stalls the whole pipeline. Four lanes each produce one output coefficient; the
// seen map is a 625-entry RAM with one read and one write per cycle, tagged with a
// 4-bit run mark so a run end needs no sweep. After reset, and after every fifteenth
// run end, the map is swept at one entry per cycle with tready low. The matrix
// registers may be written at any time and take effect on the next accepted vector.
module module_negacyclic_image_counter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mnic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mnic_pkg::COEF_W-1:0]       i_cfg_data,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // vec0_coef0..vec0_coef3, vec1_coef0..vec1_coef3, two bits each
    input  wire logic [mnic_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // last_vector
    input  wire logic                              i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // image_index[9:0], first_seen[10], distinct_so_far[20:11], covers_all[21], zero
    output logic [mnic_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    // run_end
    output logic                                   o_m_axis_tlast
);
    import mnic_pkg::*;

    t_mat     r_mat;
    t_vec     vec;
    t_res_vec res;
    t_mstat   stat;
    t_stage   a_info;
    t_clr     clr;
    logic     accept;

    logic     r_a_vld;
    logic     r_a_last;
    t_ep      r_a_ep;
    t_ep      r_ep_in;
    logic     r_hold;
    logic     r_clr_act;
    t_addr    r_clr_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PARAM_M; k++) begin
                for (int i = 0; i < PARAM_N; i++) begin
                    r_mat[k][i] <= '0;
                end
            end
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(CFG_NUM)) begin
            r_mat[i_cfg_index[LANE_W +: ROW_W]][i_cfg_index[LANE_W-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < PARAM_M; k++) begin
            for (int j = 0; j < PARAM_N; j++) begin
                vec[k][j] = i_s_axis_tdata[(k * PARAM_N + j) * XV_W +: XV_W];
            end
        end
    end

    assign o_s_axis_tready = stat.en && !r_hold;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    for (genvar g = 0; g < PARAM_N; g++) begin : g_lane
        mnic_lane u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_lane (LANE_W'(g)),
            .i_mat  (r_mat),
            .i_vec  (vec),
            .o_res  (res[g])
        );
    end

    // run marks 1..EP_MAX; zero is the swept value and never matches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_ep_in    <= t_ep'(1);
            r_hold     <= 1'b1;
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (stat.en) begin
                r_a_vld <= accept;
            end
            if (accept && i_s_axis_tlast) begin
                if (r_ep_in == t_ep'(EP_MAX)) begin
                    r_hold <= 1'b1;
                end else begin
                    r_ep_in <= r_ep_in + t_ep'(1);
                end
            end
            if (r_clr_act) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(IMG_COUNT - 1)) begin
                    r_clr_act <= 1'b0;
                    r_hold    <= 1'b0;
                    r_ep_in   <= t_ep'(1);
                end
            end else if (r_hold && !r_a_vld && !stat.b_vld) begin
                r_clr_act  <= 1'b1;
                r_clr_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_last <= i_s_axis_tlast;
            r_a_ep   <= r_ep_in;
        end
    end

    assign a_info.vld  = r_a_vld;
    assign a_info.last = r_a_last;
    assign a_info.ep   = r_a_ep;
    assign clr.active  = r_clr_act;
    assign clr.addr    = r_clr_addr;

    mnic_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (res),
        .i_a             (a_info),
        .i_clr           (clr),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_act |-> !o_s_axis_tready && !r_a_vld)
        else $error("request taken while the seen map is swept");

    a_mark_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_ep_in != '0)
        else $error("item tagged with the swept run mark");

    a_wrap_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast && r_ep_in == t_ep'(EP_MAX)) |=> !o_s_axis_tready)
        else $error("input open after run mark wrap");
`endif

endmodule

`default_nettype wire
